FILE: rtl/mea_pkg.sv
package mea_pkg;

  localparam int MAX_CONTACTS_DEF = 16;
  localparam int NUM_VALUES       = 8;
  localparam int LANE_W           = 3;
  localparam int BIT_X            = 6;
  localparam int BIT_Y            = 7;

  localparam int VALUE_W  = 32;
  localparam int TIME_W   = 42;
  localparam int USEC_W   = 20;
  localparam int SEC_W    = 32;
  localparam int USMS_W   = 11;
  localparam int BTN_W    = 3;

  localparam logic [9:0]  MS_PER_S = 10'd1000;
  localparam logic [30:0] MS_RECIP = 31'd1099511628;
  localparam int          MS_SHIFT = 40;
  localparam int          PROD_W   = USEC_W + 31;

  localparam logic [4:0] TYPE_SYN = 5'd0;
  localparam logic [4:0] TYPE_KEY = 5'd1;
  localparam logic [4:0] TYPE_ABS = 5'd3;

  localparam logic [9:0] SYN_PACKET_END = 10'h000;
  localparam logic [9:0] SYN_CONTACT    = 10'h002;

  localparam logic [9:0] KEY_LEFT   = 10'h110;
  localparam logic [9:0] KEY_RIGHT  = 10'h111;
  localparam logic [9:0] KEY_MIDDLE = 10'h112;
  localparam logic [9:0] KEY_TOUCH  = 10'h14A;

  localparam logic [9:0] ABS_CONTACT_MAJOR = 10'h030;
  localparam logic [9:0] ABS_TOUCH_MINOR   = 10'h031;
  localparam logic [9:0] ABS_WIDTH_MAJOR   = 10'h032;
  localparam logic [9:0] ABS_WIDTH_MINOR   = 10'h033;
  localparam logic [9:0] ABS_ORIENT        = 10'h034;
  localparam logic [9:0] ABS_POS_X         = 10'h035;
  localparam logic [9:0] ABS_POS_Y         = 10'h036;
  localparam logic [9:0] ABS_PRESSURE      = 10'h03A;

  localparam logic [1:0] BUTTON_LEFT_BIT   = 2'd0;
  localparam logic [1:0] BUTTON_MIDDLE_BIT = 2'd1;
  localparam logic [1:0] BUTTON_RIGHT_BIT  = 2'd2;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } lane_sel_t;

  function automatic lane_sel_t abs_lane(input logic [9:0] code);
    lane_sel_t s;
    s.hit  = 1'b1;
    s.lane = '0;
    case (code)
      ABS_CONTACT_MAJOR: s.lane = 3'd0;
      ABS_TOUCH_MINOR:   s.lane = 3'd1;
      ABS_WIDTH_MAJOR:   s.lane = 3'd2;
      ABS_WIDTH_MINOR:   s.lane = 3'd3;
      ABS_ORIENT:        s.lane = 3'd4;
      ABS_PRESSURE:      s.lane = 3'd5;
      ABS_POS_X:         s.lane = 3'd6;
      ABS_POS_Y:         s.lane = 3'd7;
      default:           s.hit  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/multitouch_event_assembler.sv
// channel | direction | words
// in      | sink      | event_type, event_code, event_value, time_seconds, time_microseconds
// out     | source    | contact_major .. position_y, present_mask, buttons, time_ms, last
//
// Key, absolute and contact-end words are accepted back to back.
// A report word forms the millisecond time (multiply, then add), then for each contact
// reads its row of the value memory and loads the output register.
// The input is held off from a report word until the final result is in the output register.
// A stalled output holds the readout; synchronous reset needs no clearing pass.
module multitouch_event_assembler #(
  parameter int MAX_CONTACTS = mea_pkg::MAX_CONTACTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [4:0]          event_type,
  input  logic [9:0]          event_code,
  input  logic signed [31:0]  event_value,
  input  logic [31:0]         time_seconds,
  input  logic [19:0]         time_microseconds,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  contact_major,
  output logic signed [31:0]  touch_minor,
  output logic signed [31:0]  width_major,
  output logic signed [31:0]  width_minor,
  output logic signed [31:0]  orientation,
  output logic signed [31:0]  pressure,
  output logic signed [31:0]  position_x,
  output logic signed [31:0]  position_y,
  output logic [7:0]          present_mask,
  output logic [2:0]          buttons,
  output logic [41:0]         time_ms,
  output logic                last
);

  localparam int CNT_W = $clog2(MAX_CONTACTS + 1);
  localparam int IDX_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CONTACTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TIME = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state;

  logic [mea_pkg::NUM_VALUES-1:0][mea_pkg::VALUE_W-1:0] value_mem [MAX_CONTACTS];
  logic [mea_pkg::NUM_VALUES-1:0][mea_pkg::VALUE_W-1:0] rd_row;

  logic [7:0]                 kept_masks [MAX_CONTACTS];
  logic [7:0]                 building_mask;
  logic [CNT_W-1:0]           slots_filled;
  logic [CNT_W-1:0]           contact_count;
  logic                       activity_seen;
  logic [mea_pkg::BTN_W-1:0]  button_bits;
  logic [mea_pkg::TIME_W-1:0] packet_time;
  logic [mea_pkg::TIME_W-1:0] sec_ms;
  logic [mea_pkg::USMS_W-1:0] usec_ms;
  logic [IDX_W-1:0]           idx;

  logic                       accept;
  logic                       slot_free;
  logic [IDX_W-1:0]           slot_row;
  mea_pkg::lane_sel_t         lsel;
  logic                       wr_en;
  logic                       rd_en;
  logic                       is_report;
  logic                       load;
  logic                       n_zero;
  logic                       is_last;
  logic [7:0]                 cur_mask;
  logic [mea_pkg::PROD_W-1:0] usec_prod;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = (slots_filled < MAX_CNT);
  assign slot_row  = slots_filled[IDX_W-1:0];
  assign lsel      = mea_pkg::abs_lane(event_code);
  assign wr_en     = accept && (event_type == mea_pkg::TYPE_ABS) && lsel.hit && slot_free;
  assign rd_en     = (state == S_READ);
  assign is_report = accept && (event_type == mea_pkg::TYPE_SYN) &&
                     (event_code == mea_pkg::SYN_PACKET_END);
  assign load      = (state == S_LOAD) && (!out_valid || out_ready);
  assign n_zero    = (contact_count == '0);
  assign is_last   = n_zero || (CNT_W'(idx) == contact_count - CNT_W'(1));
  assign cur_mask  = n_zero ? 8'd0 : kept_masks[idx];
  assign usec_prod = mea_pkg::PROD_W'(time_microseconds) * mea_pkg::PROD_W'(mea_pkg::MS_RECIP);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[slot_row][lsel.lane] <= event_value;
    end
    if (rd_en) begin
      rd_row <= value_mem[idx];
    end
    if (is_report) begin
      sec_ms  <= mea_pkg::TIME_W'(time_seconds) * mea_pkg::TIME_W'(mea_pkg::MS_PER_S);
      usec_ms <= mea_pkg::USMS_W'(usec_prod >> mea_pkg::MS_SHIFT);
    end
    if (state == S_TIME) begin
      packet_time <= sec_ms + mea_pkg::TIME_W'(usec_ms);
    end
    if (load) begin
      contact_major <= cur_mask[0] ? rd_row[0] : '0;
      touch_minor   <= cur_mask[1] ? rd_row[1] : '0;
      width_major   <= cur_mask[2] ? rd_row[2] : '0;
      width_minor   <= cur_mask[3] ? rd_row[3] : '0;
      orientation   <= cur_mask[4] ? rd_row[4] : '0;
      pressure      <= cur_mask[5] ? rd_row[5] : '0;
      position_x    <= cur_mask[6] ? rd_row[6] : '0;
      position_y    <= cur_mask[7] ? rd_row[7] : '0;
      present_mask  <= cur_mask;
      buttons       <= button_bits;
      time_ms       <= packet_time;
      last          <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      building_mask <= '0;
      slots_filled  <= '0;
      contact_count <= '0;
      activity_seen <= 1'b0;
      button_bits   <= '0;
      idx           <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < MAX_CONTACTS; i++) begin
        kept_masks[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (event_type)
              mea_pkg::TYPE_SYN: begin
                if (event_code == mea_pkg::SYN_PACKET_END) begin
                  if (activity_seen) begin
                    contact_count <= slots_filled;
                  end
                  activity_seen <= 1'b0;
                  slots_filled  <= '0;
                  building_mask <= '0;
                  state         <= S_TIME;
                end else if (event_code == mea_pkg::SYN_CONTACT) begin
                  if (slot_free && building_mask[mea_pkg::BIT_X] &&
                      building_mask[mea_pkg::BIT_Y]) begin
                    kept_masks[slot_row] <= building_mask;
                    slots_filled         <= slots_filled + CNT_W'(1);
                  end
                  building_mask <= '0;
                end
              end
              mea_pkg::TYPE_KEY: begin
                case (event_code)
                  mea_pkg::KEY_TOUCH:  activity_seen <= 1'b1;
                  mea_pkg::KEY_LEFT:
                    button_bits[mea_pkg::BUTTON_LEFT_BIT]   <= (event_value != 0);
                  mea_pkg::KEY_MIDDLE:
                    button_bits[mea_pkg::BUTTON_MIDDLE_BIT] <= (event_value != 0);
                  mea_pkg::KEY_RIGHT:
                    button_bits[mea_pkg::BUTTON_RIGHT_BIT]  <= (event_value != 0);
                  default: ;
                endcase
              end
              mea_pkg::TYPE_ABS: begin
                if (lsel.hit) begin
                  activity_seen <= 1'b1;
                  if (slot_free) begin
                    building_mask[lsel.lane] <= 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_TIME: begin
          idx   <= '0;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_filled <= MAX_CNT)
    else $error("slots_filled beyond MAX_CONTACTS");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    contact_count <= MAX_CNT)
    else $error("contact_count beyond MAX_CONTACTS");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    is_report |=> (state == S_TIME) && (slots_filled == '0) && !activity_seen &&
                  (building_mask == '0))
    else $error("report word did not close the packet");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOAD) && !n_zero) |-> (CNT_W'(idx) < contact_count))
    else $error("readout index past contact count");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_LOAD) |-> !wr_en)
    else $error("value memory written during readout");
`endif

endmodule
